>>> rtl/tlf_pkg.sv
// shared types and constants for the trace line filter
// no dependencies; imported by every rtl file of the block
`default_nettype none

package tlf_pkg;

	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 24;
	localparam int PAT_W   = 64;
	localparam int PLEN_W  = 4;
	localparam int CFG_IDX_W = 3;

	localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
	localparam logic [BYTE_W-1:0]  NEWLINE_BYTE = 8'd10;
	localparam logic [BYTE_W-1:0]  LEVEL_MAX    = '1;

	// operation codes
	localparam logic OP_DATA = 1'b0;
	localparam logic OP_END  = 1'b1;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_KEEP_LEVEL     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REPORT_LIMIT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THREAD_LIMIT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_CHAR     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COMMENT_CHAR   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_END_CHAR  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_THREAD_PATTERN = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd7;

	typedef struct packed {
		logic              operation;
		logic [BYTE_W-1:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              is_end;
		logic              abort_line;
	} out_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  keep_level;
		logic [COUNT_W-1:0] report_limit;
		logic [COUNT_W-1:0] thread_limit;
		logic [BYTE_W-1:0]  level_delim;
		logic [BYTE_W-1:0]  comment_mark;
		logic [BYTE_W-1:0]  line_end_char;
		logic [PAT_W-1:0]   thread_pattern;
		logic [PLEN_W-1:0]  pattern_length;
	} cfg_t;

endpackage

`default_nettype wire

>>> rtl/tlf_cfg.sv
// configuration register file of the trace line filter
// depends on tlf_pkg for the register indexes and the cfg_t bundle
`default_nettype none

module tlf_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [tlf_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [tlf_pkg::PAT_W-1:0]      wr_data,
	output tlf_pkg::cfg_t                       cfg
);
	import tlf_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.keep_level     <= 8'd1;
			cfg_q.report_limit   <= '0;
			cfg_q.thread_limit   <= '0;
			cfg_q.level_delim    <= 8'd32;
			cfg_q.comment_mark   <= 8'd35;
			cfg_q.line_end_char  <= 8'd10;
			cfg_q.thread_pattern <= '0;
			cfg_q.pattern_length <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_KEEP_LEVEL:     cfg_q.keep_level     <= wr_data[BYTE_W-1:0];
				REG_REPORT_LIMIT:   cfg_q.report_limit   <= wr_data[COUNT_W-1:0];
				REG_THREAD_LIMIT:   cfg_q.thread_limit   <= wr_data[COUNT_W-1:0];
				REG_LEVEL_CHAR:     cfg_q.level_delim    <= wr_data[BYTE_W-1:0];
				REG_COMMENT_CHAR:   cfg_q.comment_mark   <= wr_data[BYTE_W-1:0];
				REG_LINE_END_CHAR:  cfg_q.line_end_char  <= wr_data[BYTE_W-1:0];
				REG_THREAD_PATTERN: cfg_q.thread_pattern <= wr_data;
				REG_PATTERN_LENGTH: cfg_q.pattern_length <= wr_data[PLEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> rtl/tlf_match.sv
// thread pattern comparator over the window of recent comment bytes
// depends on tlf_pkg for widths
`default_nettype none

module tlf_match #(
	parameter int PATTERN_CHARS = 8
) (
	input  wire logic [8*PATTERN_CHARS-1:0]     recent,
	input  wire logic [tlf_pkg::PAT_W-1:0]      pattern,
	input  wire logic [tlf_pkg::PLEN_W-1:0]     plen,
	output logic                                hit
);
	import tlf_pkg::*;

	logic [PATTERN_CHARS:1] len_hit;

	// newest byte sits at the top; a pattern of length l lines up with the top l bytes
	always_comb begin
		for (int l = 1; l <= PATTERN_CHARS; l++) begin
			len_hit[l] = 1'b1;
			for (int k = 0; k < l; k++) begin
				if (recent[8*(PATTERN_CHARS-l+k) +: 8] != pattern[8*k +: 8])
					len_hit[l] = 1'b0;
			end
		end
	end

	always_comb begin
		hit = 1'b0;
		for (int l = 1; l <= PATTERN_CHARS; l++) begin
			if (plen == PLEN_W'(l))
				hit = len_hit[l];
		end
	end

endmodule

`default_nettype wire

>>> rtl/tlf_core.sv
// line state engine: classifies lines, copies kept bytes, keeps the counters
// depends on tlf_pkg and tlf_match
`default_nettype none

module tlf_core #(
	parameter int PATTERN_CHARS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire tlf_pkg::in_item_t item,
	input  wire tlf_pkg::cfg_t     cfg,
	output logic                   res_valid,
	output tlf_pkg::out_item_t     res
);
	import tlf_pkg::*;

	localparam int WIN_W = 8 * PATTERN_CHARS;
	localparam int BIL_W = $clog2(PATTERN_CHARS + 1);
	localparam logic [BIL_W-1:0] BIL_MAX = BIL_W'(PATTERN_CHARS);

	typedef enum logic [1:0] {
		PH_START,
		PH_COMMENT,
		PH_KEEP,
		PH_DROP
	} phase_t;

	phase_t             phase_q, phase_n;
	logic [BYTE_W-1:0]  dcount_q, dcount_n;
	logic [WIN_W-1:0]   recent_q, recent_n;
	logic [BIL_W-1:0]   bil_q, bil_n;
	logic               seen_q, seen_n;
	logic [COUNT_W-1:0] tcount_q, tcount_n;
	logic [COUNT_W-1:0] rcount_q, rcount_n;
	logic               stopped_q, stopped_n;

	logic [PLEN_W-1:0]  plen;
	logic [BYTE_W-1:0]  b;
	logic [WIN_W-1:0]   recent_push;
	logic [BIL_W-1:0]   bil_push;
	logic               seen_push;
	logic               hit;
	logic [BYTE_W-1:0]  dcount_copy;
	logic               copy_emit;
	logic               thread_ok;

	function automatic logic is_alnum(input logic [BYTE_W-1:0] v);
		return (v >= 8'd48 && v <= 8'd57) || (v >= 8'd65 && v <= 8'd90) ||
			(v >= 8'd97 && v <= 8'd122);
	endfunction

	assign b    = item.data_byte;
	assign plen = (cfg.pattern_length > PLEN_W'(PATTERN_CHARS)) ?
		PLEN_W'(PATTERN_CHARS) : cfg.pattern_length;

	// comment window shift and pattern test
	assign recent_push = {b, recent_q[WIN_W-1:8]};
	assign bil_push    = (bil_q < BIL_MAX) ? bil_q + 1'b1 : bil_q;

	tlf_match #(.PATTERN_CHARS(PATTERN_CHARS)) u_match (
		.recent  (recent_push),
		.pattern (cfg.thread_pattern),
		.plen    (plen),
		.hit     (hit)
	);

	assign seen_push = seen_q || (plen == '0) ||
		((PLEN_W'(bil_push) >= plen) && hit);

	// level cut for kept bytes
	assign dcount_copy = (b == cfg.level_delim && dcount_q < LEVEL_MAX) ?
		dcount_q + 1'b1 : dcount_q;
	assign copy_emit   = dcount_copy < cfg.keep_level;
	assign thread_ok   = (cfg.thread_limit == '0) || (tcount_q < cfg.thread_limit);

	always_comb begin
		phase_n   = phase_q;
		dcount_n  = dcount_q;
		recent_n  = recent_q;
		bil_n     = bil_q;
		seen_n    = seen_q;
		tcount_n  = tcount_q;
		rcount_n  = rcount_q;
		stopped_n = stopped_q;
		res_valid = 1'b0;
		res       = '0;

		if (item.operation == OP_END) begin
			res_valid      = 1'b1;
			res.is_end     = 1'b1;
			res.abort_line = !stopped_q && phase_q == PH_KEEP;
			phase_n   = PH_START;
			dcount_n  = '0;
			recent_n  = '0;
			bil_n     = '0;
			seen_n    = 1'b0;
			tcount_n  = '0;
			rcount_n  = '0;
			stopped_n = 1'b0;
		end else if (!stopped_q) begin
			if (b == cfg.line_end_char) begin
				unique case (phase_q)
					PH_START: begin
						if (cfg.comment_mark == '0 && plen == '0)
							tcount_n = '0;
					end
					PH_COMMENT: begin
						if (seen_q)
							tcount_n = '0;
					end
					PH_KEEP: begin
						res_valid    = 1'b1;
						res.out_byte = NEWLINE_BYTE;
						if (rcount_q < COUNT_MAX)
							rcount_n = rcount_q + 1'b1;
						if (tcount_q < COUNT_MAX)
							tcount_n = tcount_q + 1'b1;
					end
					default: ;
				endcase
				phase_n  = PH_START;
				dcount_n = '0;
				recent_n = '0;
				bil_n    = '0;
				seen_n   = 1'b0;
				stopped_n = (cfg.report_limit != '0) && (rcount_n >= cfg.report_limit);
			end else begin
				unique case (phase_q)
					PH_START: begin
						if (b == cfg.comment_mark) begin
							phase_n  = PH_COMMENT;
							recent_n = recent_push;
							bil_n    = bil_push;
							seen_n   = seen_push;
						end else if (is_alnum(b) && thread_ok) begin
							phase_n      = PH_KEEP;
							dcount_n     = dcount_copy;
							res_valid    = copy_emit;
							res.out_byte = b;
						end else begin
							phase_n = PH_DROP;
						end
					end
					PH_COMMENT: begin
						recent_n = recent_push;
						bil_n    = bil_push;
						seen_n   = seen_push;
					end
					PH_KEEP: begin
						dcount_n     = dcount_copy;
						res_valid    = copy_emit;
						res.out_byte = b;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			dcount_q  <= '0;
			recent_q  <= '0;
			bil_q     <= '0;
			seen_q    <= 1'b0;
			tcount_q  <= '0;
			rcount_q  <= '0;
			stopped_q <= 1'b0;
		end else if (advance) begin
			phase_q   <= phase_n;
			dcount_q  <= dcount_n;
			recent_q  <= recent_n;
			bil_q     <= bil_n;
			seen_q    <= seen_n;
			tcount_q  <= tcount_n;
			rcount_q  <= rcount_n;
			stopped_q <= stopped_n;
		end
	end

endmodule

`default_nettype wire

>>> rtl/trace_line_filter_top.sv
// trace line filter top level: input register, line engine, result register
// depends on tlf_pkg, tlf_cfg and tlf_core (which uses tlf_match)
// path: a request passes the input register and then the result register before its result is offered
// throughput: one byte per cycle while out_ready is high; no iteration anywhere
// reset: arst_n clears all line state, counters and both valid flags, and loads
// the register reset values; no clearing pass, the block takes requests at once
`default_nettype none

module trace_line_filter_top #(
	parameter int PATTERN_CHARS = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// byte request channel
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire tlf_pkg::in_item_t             in_data,
	// result channel
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output tlf_pkg::out_item_t                 out_data,
	// register write channel
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [tlf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tlf_pkg::PAT_W-1:0]     cfg_wdata
);
	import tlf_pkg::*;

	// input register stage
	logic      valid_s1;
	in_item_t  item_s1;

	// result register
	logic      out_valid_q;
	out_item_t out_data_q;

	cfg_t      cfg;
	logic      advance;
	logic      res_valid;
	out_item_t res;

	// the register file is always free; writes must come only while the filter is idle (not enforced here)
	assign cfg_ready = 1'b1;

	tlf_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_wdata),
		.cfg      (cfg)
	);

	// stage 1 moves on whenever the result register is empty or being emptied,
	// whether or not this byte produces a result
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// line engine: state update and result decision in one pass
	tlf_core #(.PATTERN_CHARS(PATTERN_CHARS)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item      (item_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register: loads on advance, drains when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

>>> rtl/tlf_checker.sv
// port-level checks for the trace line filter, bound to the top level
// depends on tlf_pkg for the result type
`default_nettype none

module tlf_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire tlf_pkg::out_item_t out_data
);
	import tlf_pkg::*;

	// the end result always carries a zero byte
	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_end |-> out_data.out_byte == '0)
		else $error("end result with non-zero byte");

	// abort only ever flags the end result
	a_abort_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.abort_line |-> out_data.is_end)
		else $error("abort_line on a data result");

	// with the result register empty the input side never stalls
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

endmodule

bind trace_line_filter_top tlf_checker u_tlf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

>>> tb/sv/tlf_line_checker.sv
`timescale 1ns / 1ps
// result checker for trace_line_filter_top: tracks register writes and accepted byte
// requests, predicts each result and compares it with the result channel
// depends on tlf_pkg only

module tlf_line_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  tlf_pkg::in_item_t             in_data,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  tlf_pkg::out_item_t            out_data,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [tlf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tlf_pkg::PAT_W-1:0]     cfg_wdata,
	output int                            fail_count,
	output int                            pending,
	output int                            live_requests,
	output int                            results_seen,
	output int                            ends_seen,
	output int                            aborts_seen
);
	import tlf_pkg::*;

	localparam int PATTERN_CHARS = 8;

	localparam cfg_t CFG_AT_RESET = '{
		keep_level: 8'd1, report_limit: '0, thread_limit: '0, level_delim: 8'h20,
		comment_mark: 8'h23, line_end_char: 8'h0A, thread_pattern: '0, pattern_length: '0
	};

	typedef enum logic [1:0] {LP_START, LP_COMMENT, LP_KEEP, LP_DROP} line_phase_t;

	cfg_t               regs;
	line_phase_t        phase;
	logic [BYTE_W-1:0]  delim_cnt;
	logic [63:0]        tail_bytes;
	logic [3:0]         line_len;
	logic               pat_hit;
	logic [COUNT_W-1:0] thr_cnt;
	logic [COUNT_W-1:0] rep_cnt;
	logic               halted;
	out_item_t          results_due[$];

	function automatic int eff_pattern_len();
		return (regs.pattern_length > 4'd8) ? PATTERN_CHARS : int'(regs.pattern_length);
	endfunction

	function automatic void clear_line();
		phase = LP_START;
		delim_cnt = '0;
		tail_bytes = '0;
		line_len = '0;
		pat_hit = 1'b0;
	endfunction

	function automatic void clear_report();
		clear_line();
		thr_cnt = '0;
		rep_cnt = '0;
		halted = 1'b0;
	endfunction

	// newest byte enters at the top, the pattern is compared against the newest bytes
	function automatic void note_comment_byte(logic [BYTE_W-1:0] b);
		int          plen;
		logic [63:0] mask;
		plen = eff_pattern_len();
		tail_bytes = {b, tail_bytes[63:8]};
		if (line_len < PATTERN_CHARS) line_len++;
		if (plen == 0) begin
			pat_hit = 1'b1;
		end else if (line_len >= plen) begin
			mask = (plen == PATTERN_CHARS) ? '1 : ((64'd1 << (8 * plen)) - 64'd1);
			if (((tail_bytes >> (8 * (PATTERN_CHARS - plen))) & mask) ==
			    (regs.thread_pattern & mask))
				pat_hit = 1'b1;
		end
	endfunction

	function automatic logic below_cut(logic [BYTE_W-1:0] b);
		if (b == regs.level_delim && delim_cnt != LEVEL_MAX) delim_cnt++;
		return delim_cnt < regs.keep_level;
	endfunction

	function automatic logic filter_request(in_item_t req, output out_item_t res);
		logic [BYTE_W-1:0] b;
		logic              hit;
		b = req.data_byte;
		res = '0;
		hit = 1'b0;
		if (req.operation == OP_END) begin
			res.is_end = 1'b1;
			res.abort_line = !halted && phase == LP_KEEP;
			clear_report();
			return 1'b1;
		end
		if (halted) return 1'b0;
		if (b == regs.line_end_char) begin
			case (phase)
				LP_START: if (regs.comment_mark == 8'd0 && eff_pattern_len() == 0) thr_cnt = '0;
				LP_COMMENT: if (pat_hit) thr_cnt = '0;
				LP_KEEP: begin
					res.out_byte = NEWLINE_BYTE;
					hit = 1'b1;
					if (rep_cnt != COUNT_MAX) rep_cnt++;
					if (thr_cnt != COUNT_MAX) thr_cnt++;
				end
				default: ;
			endcase
			clear_line();
			if (regs.report_limit != '0 && rep_cnt >= regs.report_limit) halted = 1'b1;
			return hit;
		end
		case (phase)
			LP_START: begin
				if (b == regs.comment_mark) begin
					phase = LP_COMMENT;
					note_comment_byte(b);
				end else if (((b >= 8'd48 && b <= 8'd57) || (b >= 8'd65 && b <= 8'd90) ||
				              (b >= 8'd97 && b <= 8'd122)) &&
				             (regs.thread_limit == '0 || thr_cnt < regs.thread_limit)) begin
					phase = LP_KEEP;
					hit = below_cut(b);
					res.out_byte = b;
				end else begin
					phase = LP_DROP;
				end
			end
			LP_COMMENT: note_comment_byte(b);
			LP_KEEP: begin
				hit = below_cut(b);
				res.out_byte = b;
			end
			default: ;
		endcase
		return hit;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			regs = CFG_AT_RESET;
			clear_report();
			results_due.delete();
			fail_count = 0;
			live_requests = 0;
			results_seen = 0;
			ends_seen = 0;
			aborts_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_KEEP_LEVEL:     regs.keep_level = cfg_wdata[BYTE_W-1:0];
					REG_REPORT_LIMIT:   regs.report_limit = cfg_wdata[COUNT_W-1:0];
					REG_THREAD_LIMIT:   regs.thread_limit = cfg_wdata[COUNT_W-1:0];
					REG_LEVEL_CHAR:     regs.level_delim = cfg_wdata[BYTE_W-1:0];
					REG_COMMENT_CHAR:   regs.comment_mark = cfg_wdata[BYTE_W-1:0];
					REG_LINE_END_CHAR:  regs.line_end_char = cfg_wdata[BYTE_W-1:0];
					REG_THREAD_PATTERN: regs.thread_pattern = cfg_wdata;
					REG_PATTERN_LENGTH: regs.pattern_length = cfg_wdata[PLEN_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (out_data.is_end) ends_seen++;
				if (out_data.is_end && out_data.abort_line) aborts_seen++;
				if (results_due.size() == 0) begin
					$error("result with nothing expected: out_byte %0d is_end %0d abort_line %0d",
						out_data.out_byte, out_data.is_end, out_data.abort_line);
					fail_count++;
				end else begin
					want = results_due.pop_front();
					if (out_data.out_byte !== want.out_byte) begin
						$error("out_byte: expected %0d, got %0d", want.out_byte, out_data.out_byte);
						fail_count++;
					end
					if (out_data.is_end !== want.is_end) begin
						$error("is_end: expected %0d, got %0d", want.is_end, out_data.is_end);
						fail_count++;
					end
					if (out_data.abort_line !== want.abort_line) begin
						$error("abort_line: expected %0d, got %0d", want.abort_line,
							out_data.abort_line);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (in_data.operation == OP_END || !halted) live_requests++;
				if (filter_request(in_data, want)) results_due.push_back(want);
			end
		end
		pending = results_due.size();
	end

endmodule

>>> tb/sv/tb_trace_line_filter_top.sv
`timescale 1ns / 1ps
// top of the trace line filter testbench: clock, reset, byte and register requests,
// result-side back-pressure, watchdog and verdict
// depends on tlf_pkg, the rtl of trace_line_filter_top and tlf_line_checker

module tb_trace_line_filter_top;
	import tlf_pkg::*;

	// the longest correct silence is the deliberate result hold-off below; the
	// watchdog limit is set well above it
	localparam int STALL_LIMIT     = 2000;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int IDLE_PCT        = 26;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_item_t            out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PAT_W-1:0]     cfg_wdata;

	int fail_count, pending, live_requests, results_seen, ends_seen, aborts_seen;
	int stall_cycles = 0;

	cfg_t cur;            // register values as last written, shapes the stimulus
	logic steady;         // both sides stop idling while set
	logic hold_off_req;   // asks the receiver for one long stall
	logic hold_off_done;

	trace_line_filter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	tlf_line_checker line_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.pending       (pending),
		.live_requests (live_requests),
		.results_seen  (results_seen),
		.ends_seen     (ends_seen),
		.aborts_seen   (aborts_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// cycles since the last handshake on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
			STALL_LIMIT, pending);
		$display("trace_line_filter_top regression: fail");
		$finish;
	end

	// result side: random stalls, one long hold-off on request so that the block
	// backs up and stops taking bytes
	initial begin
		out_ready = 1'b0;
		hold_off_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req && !hold_off_done) begin
				out_ready = 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_done = 1'b1;
			end
			out_ready = steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// one byte request; entered and left at a falling edge, valid left high so that
	// the next request follows without a gap unless the sender idles
	task automatic send_request(input logic op, input logic [BYTE_W-1:0] b);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = '{operation: op, data_byte: b};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_request(OP_DATA, s[i]);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_W-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// registers change only with the block drained; bytes that give no result may
	// still sit in the two pipeline stages, hence the short pause
	task automatic apply_cfg(input cfg_t c);
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		write_reg(REG_KEEP_LEVEL, c.keep_level);
		write_reg(REG_REPORT_LIMIT, c.report_limit);
		write_reg(REG_THREAD_LIMIT, c.thread_limit);
		write_reg(REG_LEVEL_CHAR, c.level_delim);
		write_reg(REG_COMMENT_CHAR, c.comment_mark);
		write_reg(REG_LINE_END_CHAR, c.line_end_char);
		write_reg(REG_THREAD_PATTERN, c.thread_pattern);
		write_reg(REG_PATTERN_LENGTH, c.pattern_length);
		cfg_valid = 1'b0;
		cur = c;
	endtask

	function automatic logic [PAT_W-1:0] random_pattern(input int lo, input int hi);
		logic [PAT_W-1:0] p;
		for (int j = 0; j < 8; j++) p[8*j +: 8] = 8'($urandom_range(lo, hi));
		return p;
	endfunction

	// one line of the report: mostly well formed, some noise
	task automatic send_line();
		int                kind, len, plen, pat_at, k;
		logic              in_comment;
		logic [BYTE_W-1:0] b;
		kind = $urandom_range(99);
		len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
		plen = (cur.pattern_length > 4'd8) ? 8 : int'(cur.pattern_length);
		pat_at = ($urandom_range(1) == 0) ? $urandom_range(len) : -1;
		in_comment = 1'b0;
		// noise: arbitrary bytes with no regard for line structure
		if (kind < 10) begin
			repeat (len + 1) send_request(OP_DATA, 8'($urandom_range(1, 255)));
			return;
		end
		if (kind < 55) begin
			// instruction line, first byte a digit or a letter
			k = $urandom_range(61);
			b = (k < 10) ? 8'(48 + k) : (k < 36) ? 8'(55 + k) : 8'(61 + k);
			send_request(OP_DATA, b);
		end else if (kind < 75 && cur.comment_mark != 8'd0) begin
			in_comment = 1'b1;
			send_request(OP_DATA, cur.comment_mark);
		end else if (kind < 90) begin
			// dropped line, any other first byte
			do b = 8'($urandom_range(1, 255));
			while (b == cur.comment_mark || b == cur.line_end_char ||
			       (b >= 8'd48 && b <= 8'd57) || (b >= 8'd65 && b <= 8'd90) ||
			       (b >= 8'd97 && b <= 8'd122));
			send_request(OP_DATA, b);
		end else begin
			len = 0;   // empty line
		end
		for (int i = 0; i <= len; i++) begin
			// comments carry the thread pattern at a random place about half the time
			if (in_comment && i == pat_at)
				for (int j = 0; j < plen; j++) send_request(OP_DATA, cur.thread_pattern[8*j +: 8]);
			if (i < len) begin
				k = $urandom_range(7);
				case ($urandom_range(5))
					0: b = cur.level_delim;
					1: b = cur.thread_pattern[8*k +: 8];
					default: b = 8'($urandom_range(1, 255));
				endcase
				if (b == 8'd0 || b == cur.line_end_char) b = 8'($urandom_range(48, 57));
				send_request(OP_DATA, b);
			end
		end
		// now and then the report ends before the terminator
		if ($urandom_range(14) == 0)
			send_request(OP_END, 8'($urandom_range(1, 255)));
		else if (cur.line_end_char != 8'd0)
			send_request(OP_DATA, cur.line_end_char);
	endtask

	// lines until n more requests have reached the block's logic; bytes swallowed
	// after the report limit do not count
	task automatic run_lines(input int n, input int end_pct);
		int goal;
		goal = live_requests + n;
		while (live_requests < goal) begin
			send_line();
			if ($urandom_range(99) < end_pct) send_request(OP_END, 8'($urandom_range(1, 255)));
		end
	endtask

	initial begin
		cfg_t c;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		steady = 1'b0;
		hold_off_req = 1'b0;
		cur = '{keep_level: 8'd1, report_limit: '0, thread_limit: '0, level_delim: 8'h20,
			comment_mark: 8'h23, line_end_char: 8'h0A, thread_pattern: '0, pattern_length: '0};
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, reset register values
		// kept line cut at the first space, extreme byte values inside it
		send_text("Ab");
		send_request(OP_DATA, 8'h01);
		send_request(OP_DATA, 8'hFF);
		send_text(" z\n");
		send_text("-x\n");   // dropped line
		send_text("#q\n");   // comment, empty pattern always matches
		send_text("\n");     // empty line
		send_text("z9 \n");
		// report ends inside a kept line, then an end on an idle line
		send_text("7");
		send_request(OP_END, 8'hFF);
		send_request(OP_END, 8'h01);

		// short pattern, deeper cut; the receiver holds off once here
		c = '{keep_level: 8'd3, report_limit: '0, thread_limit: '0, level_delim: 8'h20,
			comment_mark: 8'h23, line_end_char: 8'h0A, thread_pattern: 64'h3154,
			pattern_length: 4'd2};
		apply_cfg(c);
		hold_off_req = 1'b1;
		run_lines(150, 5);

		// level zero keeps only the newline; comment byte zero makes empty lines
		// comments, and with no pattern they clear the per-thread count
		c = '{keep_level: 8'd0, report_limit: '0, thread_limit: 24'd2, level_delim: 8'h20,
			comment_mark: 8'h00, line_end_char: 8'h0A, thread_pattern: '0,
			pattern_length: 4'd0};
		apply_cfg(c);
		run_lines(80, 5);

		// widest cut, small report limit, pattern length beyond eight, top terminator
		c = '{keep_level: 8'hFF, report_limit: 24'd3, thread_limit: COUNT_MAX,
			level_delim: 8'h01, comment_mark: 8'h25, line_end_char: 8'hFF,
			thread_pattern: random_pattern(65, 90), pattern_length: 4'hF};
		apply_cfg(c);
		run_lines(100, 25);

		// full eight-byte pattern, one line per thread, no idling on either side
		c = '{keep_level: 8'd2, report_limit: COUNT_MAX, thread_limit: 24'd1,
			level_delim: 8'h2C, comment_mark: 8'h3B, line_end_char: 8'h0A,
			thread_pattern: random_pattern(97, 122), pattern_length: 4'd8};
		apply_cfg(c);
		steady = 1'b1;
		run_lines(150, 5);
		steady = 1'b0;

		// terminator zero never arrives, so only report ends close a line
		c = '{keep_level: 8'd1, report_limit: 24'd1, thread_limit: '0, level_delim: 8'h00,
			comment_mark: 8'hFF, line_end_char: 8'h00, thread_pattern: '1,
			pattern_length: 4'd8};
		apply_cfg(c);
		run_lines(40, 15);

		// random settings with small limits
		repeat (2) begin
			c.keep_level = 8'($urandom_range(4));
			c.report_limit = 24'($urandom_range(5));
			c.thread_limit = 24'($urandom_range(3));
			c.level_delim = 8'($urandom_range(1, 255));
			c.comment_mark = 8'($urandom_range(0, 255));
			c.line_end_char = 8'($urandom_range(1, 255));
			c.thread_pattern = random_pattern(1, 255);
			c.pattern_length = 4'($urandom_range(15));
			apply_cfg(c);
			run_lines(80, 10);
		end

		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		$display("covered %0d byte requests under eight register settings, %0d results compared",
			live_requests, results_seen);
		$display("%0d report ends seen, %0d of them discarding a partial line",
			ends_seen, aborts_seen);
		if (fail_count == 0)
			$display("trace_line_filter_top regression: pass");
		else
			$display("trace_line_filter_top regression: fail");
		$finish;
	end

endmodule

>>> trace_line_filter_top.f
rtl/tlf_pkg.sv
rtl/tlf_cfg.sv
rtl/tlf_match.sv
rtl/tlf_core.sv
rtl/trace_line_filter_top.sv
rtl/tlf_checker.sv
tb/sv/tlf_line_checker.sv
tb/sv/tb_trace_line_filter_top.sv
